[rtl/sitda_pkg.sv]
// Package for the signed integer to decimal ASCII converter.
// Holds the controller state type and the ASCII codes. No dependencies.
package sitda_pkg;

	// Width of one ASCII character on the output.
	localparam int CHAR_BITS = 6;

	// ASCII codes for the minus sign and the digit zero.
	localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;
	localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 6'd48;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_TRIM,
		ST_EMIT
	} conv_state_t;

endpackage

[rtl/signed_int_to_decimal_ascii.sv]
// Signed integer to decimal ASCII text converter, top level.
// Depends on sitda_pkg for the state type and the ASCII codes.
//
// Usage:
// The input channel (value, in_valid, in_stall) takes one two's complement
// integer of DATA_BITS bits per word. The output channel (character, last,
// out_valid, out_stall) gives its decimal text one ASCII character per word:
// a minus sign for negative values, then the digits, most significant first,
// without leading zeros. The final character of each value has last set.
// Operation: after a word is accepted, the magnitude is shifted bit by bit
// through a double-dabble BCD register, then leading zero digits are dropped
// at one digit per cycle until the first nonzero digit is on top, and then the
// characters leave at one per cycle while the receiver does not stall.
// The block works on one value at a time and holds in_stall high until the
// final character of the current value has been loaded into the output
// register. When the receiver stalls, the output word holds and conversion
// of the remaining characters waits. Reset clears the controller and the
// output valid; the block is then ready for a new word.
module signed_int_to_decimal_ascii #(
	parameter int DATA_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [DATA_BITS-1:0]       value,
	input  logic                              in_valid,
	output logic                              in_stall,
	output logic [sitda_pkg::CHAR_BITS-1:0]   character,
	output logic                              last,
	output logic                              out_valid,
	input  logic                              out_stall
);
	import sitda_pkg::*;

	// Decimal digits needed for the largest magnitude, 2^(DATA_BITS-1).
	localparam int NDIG  = ((DATA_BITS - 1) * 1233) / 4096 + 1;
	localparam int BCD_W = NDIG * 4;
	localparam int CNT_W = $clog2(DATA_BITS + 1);
	localparam int DIG_W = $clog2(NDIG + 1);

	conv_state_t state_q, state_d;

	logic [DATA_BITS-1:0] mag_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BCD_W-1:0]     bcd_adj;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIG_W-1:0]     dig_q;
	logic                 sign_pend_q;
	logic [CHAR_BITS-1:0] char_q;
	logic                 last_q;
	logic                 out_valid_q;

	logic [3:0]           top_digit;
	logic                 accept;
	logic                 slot_free;
	logic                 conv_en;
	logic                 trim_en;
	logic                 emit_en;
	logic [DATA_BITS-1:0] neg_mag;

	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign slot_free = !out_valid_q || !out_stall;
	assign neg_mag   = ~$unsigned(value) + {{(DATA_BITS-1){1'b0}}, 1'b1};

	// Double-dabble correction: add three to every digit of five or more.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CONVERT;
			end
			ST_CONVERT: begin
				if (cnt_q == CNT_W'(1)) state_d = ST_TRIM;
			end
			ST_TRIM: begin
				if (!(top_digit == 4'd0 && dig_q > DIG_W'(1))) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free && !sign_pend_q && dig_q == DIG_W'(1)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller outputs.
	always_comb begin
		in_stall = 1'b1;
		conv_en  = 1'b0;
		trim_en  = 1'b0;
		emit_en  = 1'b0;
		case (state_q)
			ST_IDLE:    in_stall = 1'b0;
			ST_CONVERT: conv_en = 1'b1;
			ST_TRIM:    trim_en = (top_digit == 4'd0) && (dig_q > DIG_W'(1));
			ST_EMIT:    emit_en = slot_free;
			default:    in_stall = 1'b1;
		endcase
	end

	assign accept = in_valid && !in_stall;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Magnitude and BCD shift registers with their counters.
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q       <= value[DATA_BITS-1] ? neg_mag : $unsigned(value);
			sign_pend_q <= value[DATA_BITS-1];
			bcd_q       <= '0;
			cnt_q       <= CNT_W'(DATA_BITS);
			dig_q       <= DIG_W'(NDIG);
		end else if (conv_en) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[DATA_BITS-1]};
			mag_q <= {mag_q[DATA_BITS-2:0], 1'b0};
			cnt_q <= cnt_q - CNT_W'(1);
		end else if (trim_en) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
			dig_q <= dig_q - DIG_W'(1);
		end else if (emit_en) begin
			if (sign_pend_q) begin
				sign_pend_q <= 1'b0;
			end else begin
				bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
				dig_q <= dig_q - DIG_W'(1);
			end
		end
	end

	// Output word register: valid is control, the character is payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			if (sign_pend_q) begin
				char_q <= ASCII_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= ASCII_ZERO + {2'b00, top_digit};
				last_q <= (dig_q == DIG_W'(1));
			end
		end
	end

	assign character = char_q;
	assign last      = last_q;
	assign out_valid = out_valid_q;

endmodule
